// ===== hw/rtl/thick_line_span_generator_core_defines.svh =====
// Assertion macros shared by the span generator RTL.
`ifndef THICK_LINE_SPAN_GENERATOR_CORE_DEFINES_SVH
`define THICK_LINE_SPAN_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define TLSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlsg check failed");

// Next-cycle implication.
`define TLSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlsg check failed");

`endif

// ===== hw/rtl/tlsg_pkg.sv =====
package tlsg_pkg;

   localparam int MAX_SIZE  = 64;
   localparam int DIM_LIMIT = (MAX_SIZE < 64) ? MAX_SIZE : 64;

   localparam int COORD_W = 6;
   localparam int LEN_W   = 7;
   localparam int COLOR_W = 32;
   localparam int CSR_W   = 7;

   localparam logic [LEN_W-1:0] DIM_LIMIT_VAL = LEN_W'(DIM_LIMIT);

   typedef enum logic [0:0] {
      CSR_SPRITE_WIDTH  = 1'b0,
      CSR_SPRITE_HEIGHT = 1'b1
   } csr_index_type;

   // Microprogram addresses.
   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_SETUP,
      STEP_INIT,
      STEP_EMIT
   } step_type;

   // Jump condition: when true go to target, otherwise hold the step.
   typedef enum logic [1:0] {
      JC_ALWAYS,
      JC_START,
      JC_LAST
   } jcond_type;

   typedef struct packed {
      logic      busy;
      logic      load;
      logic      setup;
      logic      init;
      logic      emit;
      jcond_type jcond;
      step_type  target;
   } ctrl_type;

   function automatic ctrl_type rom_word(input step_type step);
      ctrl_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.load   = 1'b1;
            w.jcond  = JC_START;
            w.target = STEP_SETUP;
         end
         STEP_SETUP: begin
            w.busy   = 1'b1;
            w.setup  = 1'b1;
            w.jcond  = JC_ALWAYS;
            w.target = STEP_INIT;
         end
         STEP_INIT: begin
            w.busy   = 1'b1;
            w.init   = 1'b1;
            w.jcond  = JC_ALWAYS;
            w.target = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.busy   = 1'b1;
            w.emit   = 1'b1;
            w.jcond  = JC_LAST;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/thick_line_span_generator_core.sv =====
// Channel     Ports                          Handshake
// ----------  -----------------------------  ------------------------------------
// request     req_* fields, start, busy      word taken when start && !busy
// response    rsp_* fields, rsp_valid        word shown one cycle, no stall
// control     csr_we, csr_index, csr_wdata   register written when csr_we
//
// After an accept a line runs two setup steps, then one span per cycle from the
// single stepping unit; no new request is taken until the microprogram is back in idle.
// The first span passes the setup and init steps and the output register, then one per cycle.
// Reset returns the microprogram to idle and sets both sprite sizes to 64.
// Spans leave through a one-word output register; the receiver cannot stall.
`include "thick_line_span_generator_core_defines.svh"

module thick_line_span_generator_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tlsg_pkg::COORD_W-1:0] req_x_start,
   input  logic [tlsg_pkg::COORD_W-1:0] req_y_start,
   input  logic [tlsg_pkg::COORD_W-1:0] req_x_end,
   input  logic [tlsg_pkg::COORD_W-1:0] req_y_end,
   input  logic [tlsg_pkg::LEN_W-1:0]   req_line_thickness,
   input  logic [tlsg_pkg::COLOR_W-1:0] req_fill_color,
   output logic                         rsp_valid,
   output logic [tlsg_pkg::COORD_W-1:0] rsp_span_x,
   output logic [tlsg_pkg::COORD_W-1:0] rsp_span_y,
   output logic [tlsg_pkg::LEN_W-1:0]   rsp_span_length,
   output logic                         rsp_run_vertical,
   output logic                         rsp_span_visible,
   output logic [tlsg_pkg::COLOR_W-1:0] rsp_span_color,
   output logic                         rsp_last_span,
   input  logic                         csr_we,
   input  tlsg_pkg::csr_index_type      csr_index,
   input  logic [tlsg_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int CW = tlsg_pkg::COORD_W;
   localparam int LW = tlsg_pkg::LEN_W;

   tlsg_pkg::ctrl_type ctrl;
   logic               accept;
   logic               last;

   // configuration
   logic [LW-1:0] width_ff;
   logic [LW-1:0] height_ff;
   logic [LW-1:0] csr_sat;

   // latched request
   logic [CW-1:0]               x0_ff, y0_ff, x1_ff, y1_ff;
   logic [LW-1:0]               thick_ff;
   logic [tlsg_pkg::COLOR_W-1:0] color_ff;

   // setup results
   logic          y_major_ff;
   logic [CW-1:0] steps_ff;
   logic [CW-1:0] delta_ff;
   logic          major_neg_ff;
   logic          minor_neg_ff;

   // stepping state
   logic [CW-1:0] major_ff, major_in;
   logic [CW-1:0] minor_ff, minor_in;
   logic [LW-1:0] err_ff, err_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic signed [CW:0] dx, dy;
   logic [CW-1:0]      adx, ady;
   logic               y_major;
   logic [7:0]         err_sum;
   logic [7:0]         two_steps;
   logic               carry;

   logic [CW-1:0] px, py;
   logic [CW-1:0] clip_x, clip_y;
   logic [LW-1:0] clip_len;
   logic          clip_vis;

   tlsg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .last  (last),
      .ctrl  (ctrl)
   );

   assign busy   = ctrl.busy;
   assign accept = ctrl.load && start;

   // Saturate sizes to the sprite limit on write.
   assign csr_sat = (csr_wdata > tlsg_pkg::DIM_LIMIT_VAL) ? tlsg_pkg::DIM_LIMIT_VAL : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= (7'd64 > tlsg_pkg::DIM_LIMIT_VAL) ? tlsg_pkg::DIM_LIMIT_VAL : 7'd64;
         height_ff <= (7'd64 > tlsg_pkg::DIM_LIMIT_VAL) ? tlsg_pkg::DIM_LIMIT_VAL : 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            tlsg_pkg::CSR_SPRITE_WIDTH:  width_ff  <= csr_sat;
            tlsg_pkg::CSR_SPRITE_HEIGHT: height_ff <= csr_sat;
         endcase
      end
   end

   // Setup arithmetic on the latched endpoints.
   always_comb begin
      dx      = $signed({1'b0, x1_ff}) - $signed({1'b0, x0_ff});
      dy      = $signed({1'b0, y1_ff}) - $signed({1'b0, y0_ff});
      adx     = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      ady     = dy[CW] ? CW'(-dy) : dy[CW-1:0];
      y_major = (ady >= adx);
   end

   // Stepping: error term holds (2*delta*i + steps) mod 2*steps.
   always_comb begin
      last      = (cnt_ff == steps_ff);
      err_sum   = {1'b0, err_ff} + {1'b0, delta_ff, 1'b0};
      two_steps = {1'b0, steps_ff, 1'b0};
      carry     = (err_sum >= two_steps);
      err_in    = carry ? LW'(err_sum - two_steps) : err_sum[LW-1:0];
      cnt_in    = cnt_ff + CW'(1);
      major_in  = major_neg_ff ? (major_ff - CW'(1)) : (major_ff + CW'(1));
      if (carry) begin
         minor_in = minor_neg_ff ? (minor_ff - CW'(1)) : (minor_ff + CW'(1));
      end else begin
         minor_in = minor_ff;
      end
      px = y_major_ff ? minor_ff : major_ff;
      py = y_major_ff ? major_ff : minor_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff    <= req_x_start;
         y0_ff    <= req_y_start;
         x1_ff    <= req_x_end;
         y1_ff    <= req_y_end;
         thick_ff <= (req_line_thickness == '0) ? LW'(1) : req_line_thickness;
         color_ff <= req_fill_color;
      end
      if (ctrl.setup) begin
         y_major_ff   <= y_major;
         steps_ff     <= y_major ? ady : adx;
         delta_ff     <= y_major ? adx : ady;
         major_neg_ff <= y_major ? (dy <= 0) : (dx <= 0);
         minor_neg_ff <= y_major ? dx[CW] : dy[CW];
      end
      if (ctrl.init) begin
         major_ff <= y_major_ff ? y0_ff : x0_ff;
         minor_ff <= y_major_ff ? x0_ff : y0_ff;
         err_ff   <= {1'b0, steps_ff};
         cnt_ff   <= '0;
      end else if (ctrl.emit) begin
         major_ff <= major_in;
         minor_ff <= minor_in;
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
      end
   end

   tlsg_clip u_clip (
      .px          (px),
      .py          (py),
      .half        (thick_ff[LW-1:1]),
      .thick       (thick_ff),
      .vert        (!y_major_ff),
      .width       (width_ff),
      .height      (height_ff),
      .span_x      (clip_x),
      .span_y      (clip_y),
      .span_length (clip_len),
      .visible     (clip_vis)
   );

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_span_x       <= clip_x;
         rsp_span_y       <= clip_y;
         rsp_span_length  <= clip_len;
         rsp_run_vertical <= !y_major_ff;
         rsp_span_visible <= clip_vis;
         rsp_span_color   <= color_ff;
         rsp_last_span    <= last;
      end
   end

   `TLSG_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TLSG_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_last_span, !rsp_valid)
   `TLSG_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_valid, $past(busy))

endmodule

// ===== hw/rtl/tlsg_seq.sv =====
module tlsg_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               last,
   output tlsg_pkg::ctrl_type ctrl
);

   tlsg_pkg::step_type pc_ff;
   tlsg_pkg::step_type pc_in;
   logic               take;

   always_comb begin
      ctrl = tlsg_pkg::rom_word(pc_ff);
   end

   always_comb begin
      unique case (ctrl.jcond)
         tlsg_pkg::JC_ALWAYS: take = 1'b1;
         tlsg_pkg::JC_START:  take = start;
         tlsg_pkg::JC_LAST:   take = last;
         default:             take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tlsg_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/tlsg_clip.sv =====
module tlsg_clip (
   input  logic [tlsg_pkg::COORD_W-1:0] px,
   input  logic [tlsg_pkg::COORD_W-1:0] py,
   input  logic [tlsg_pkg::COORD_W-1:0] half,
   input  logic [tlsg_pkg::LEN_W-1:0]   thick,
   input  logic                         vert,
   input  logic [tlsg_pkg::LEN_W-1:0]   width,
   input  logic [tlsg_pkg::LEN_W-1:0]   height,
   output logic [tlsg_pkg::COORD_W-1:0] span_x,
   output logic [tlsg_pkg::COORD_W-1:0] span_y,
   output logic [tlsg_pkg::LEN_W-1:0]   span_length,
   output logic                         visible
);

   logic [tlsg_pkg::COORD_W-1:0] run_pos;
   logic [tlsg_pkg::COORD_W-1:0] fix_pos;
   logic [tlsg_pkg::LEN_W-1:0]   run_lim;
   logic [tlsg_pkg::LEN_W-1:0]   fix_lim;
   logic signed [8:0]            run_lo;
   logic signed [8:0]            run_hi;
   logic signed [8:0]            run_max;
   logic signed [8:0]            lo;
   logic signed [8:0]            hi;
   logic signed [8:0]            len9;

   always_comb begin
      // Run direction is along x for horizontal runs, along y for vertical.
      run_pos = vert ? py : px;
      fix_pos = vert ? px : py;
      run_lim = vert ? height : width;
      fix_lim = vert ? width : height;

      run_lo  = $signed({3'b000, run_pos}) - $signed({3'b000, half});
      run_hi  = run_lo + $signed({2'b00, thick}) - 9'sd1;
      run_max = $signed({2'b00, run_lim}) - 9'sd1;

      lo = (run_lo < 9'sd0) ? 9'sd0 : run_lo;
      hi = (run_hi < run_max) ? run_hi : run_max;

      visible = (lo <= hi) && ({1'b0, fix_pos} < fix_lim);
      len9    = hi - lo + 9'sd1;

      if (visible) begin
         span_length = len9[tlsg_pkg::LEN_W-1:0];
         span_x      = vert ? fix_pos : lo[tlsg_pkg::COORD_W-1:0];
         span_y      = vert ? lo[tlsg_pkg::COORD_W-1:0] : fix_pos;
      end else begin
         span_length = '0;
         span_x      = '0;
         span_y      = '0;
      end
   end

endmodule
